FILE: rtl/pte_pkg.sv
`timescale 1ns / 1ps

package pte_pkg;

    // topology codes of the mode register
    localparam logic [2:0] MODE_TRIS   = 3'd0;
    localparam logic [2:0] MODE_LINES  = 3'd1;
    localparam logic [2:0] MODE_TSTRIP = 3'd2;
    localparam logic [2:0] MODE_TFAN   = 3'd3;
    localparam logic [2:0] MODE_LSTRIP = 3'd4;
    localparam logic [2:0] MODE_LLOOP  = 3'd5;

    localparam int unsigned JOB_SLOTS = 4;

    // one vertex, x in the low half
    typedef struct packed {
        logic [31:0] y;
        logic [31:0] x;
    } vertex_t;

    // input transfer payload
    typedef struct packed {
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic        run_end;
    } vert_in_t;

    // output transfer payload
    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic        is_line;
        logic        last_out;
    } prim_out_t;

    // expanded work for one input vertex: slots 0..last_idx are emitted
    typedef struct packed {
        vertex_t [JOB_SLOTS-1:0] verts;
        logic [1:0]              last_idx;
        logic                    is_line;
    } job_t;

endpackage

FILE: rtl/pte_front.sv
`timescale 1ns / 1ps

module pte_front
    import pte_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mode_we,
    input  logic [2:0] mode_wdata,
    input  logic     vert_valid,
    output logic     vert_stall,
    input  vert_in_t vert,
    output logic     push,
    output job_t     push_job,
    input  logic     push_ready
);

    logic [2:0] mode_reg;
    vertex_t    first_reg, older_reg, newer_reg;
    vertex_t    first_next;
    logic [1:0] seen_reg, seen_next;
    logic       odd_reg, odd_next;
    vertex_t    cur;
    logic       accept;
    logic       emit;
    job_t       job;

    assign cur.x      = vert.vert_x;
    assign cur.y      = vert.vert_y;
    assign vert_stall = !push_ready;
    assign accept     = vert_valid && !vert_stall;

    // first vertex of the run, taken from the current one on a fresh run
    assign first_next = (seen_reg == 2'd0) ? cur : first_reg;

    // classify the vertex by topology and build its output list
    always_comb
    begin
        job       = '0;
        emit      = 1'b0;
        case (mode_reg)
            MODE_TRIS:
            begin
                job.verts[0] = cur;
                emit         = 1'b1;
            end
            MODE_LINES:
            begin
                job.verts[0] = cur;
                job.is_line  = 1'b1;
                emit         = 1'b1;
            end
            MODE_TSTRIP:
            begin
                job.verts[0] = odd_reg ? newer_reg : older_reg;
                job.verts[1] = odd_reg ? older_reg : newer_reg;
                job.verts[2] = cur;
                job.last_idx = 2'd2;
                emit         = (seen_reg == 2'd2);
            end
            MODE_TFAN:
            begin
                job.verts[0] = first_next;
                job.verts[1] = newer_reg;
                job.verts[2] = cur;
                job.last_idx = 2'd2;
                emit         = (seen_reg == 2'd2);
            end
            MODE_LSTRIP, MODE_LLOOP:
            begin
                job.is_line = 1'b1;
                if (seen_reg != 2'd0)
                begin
                    job.verts[0] = newer_reg;
                    job.verts[1] = cur;
                    job.verts[2] = cur;
                    job.verts[3] = first_next;
                    job.last_idx = (mode_reg == MODE_LLOOP && vert.run_end) ? 2'd3 : 2'd1;
                    emit         = 1'b1;
                end
                else
                begin
                    // closing segment of a one-vertex loop
                    job.verts[0] = cur;
                    job.verts[1] = first_next;
                    job.last_idx = 2'd1;
                    emit         = (mode_reg == MODE_LLOOP) && vert.run_end;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign push     = accept && emit;
    assign push_job = job;

    // run position tracking
    always_comb
    begin
        if (vert.run_end)
        begin
            seen_next = 2'd0;
            odd_next  = 1'b0;
        end
        else
        begin
            seen_next = (seen_reg == 2'd2) ? 2'd2 : seen_reg + 2'd1;
            odd_next  = !odd_reg;
        end
    end

    // mode register, run counters and vertex history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TRIS;
            seen_reg  <= 2'd0;
            odd_reg   <= 1'b0;
            first_reg <= '0;
            older_reg <= '0;
            newer_reg <= '0;
        end
        else
        begin
            if (mode_we)
            begin
                mode_reg <= mode_wdata;
            end
            if (accept)
            begin
                seen_reg  <= seen_next;
                odd_reg   <= odd_next;
                first_reg <= first_next;
                older_reg <= newer_reg;
                newer_reg <= cur;
            end
        end
    end

endmodule

FILE: rtl/pte_queue.sv
`timescale 1ns / 1ps

module pte_queue
    import pte_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic push_ready,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill level above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("queue written while full");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !head_valid) |=> head_valid)
        else $error("transfer into empty queue lost");
`endif

endmodule

FILE: rtl/pte_back.sv
`timescale 1ns / 1ps

module pte_back
    import pte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      prim_valid,
    input  logic      prim_stall,
    output prim_out_t prim
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    prim_out_t  prim_reg;
    prim_out_t  prim_next;
    logic       advance;
    logic       load;
    logic       at_last;
    vertex_t    sel;

    // output register frees up when empty or when its transfer completes
    assign advance = !valid_reg || !prim_stall;
    assign load    = advance && head_valid;
    assign at_last = (idx_reg == head_job.last_idx);
    assign pop     = load && at_last;

    assign sel = head_job.verts[idx_reg];

    // next list vertex from the head entry
    always_comb
    begin
        prim_next.out_x    = sel.x;
        prim_next.out_y    = sel.y;
        prim_next.is_line  = head_job.is_line;
        prim_next.last_out = at_last;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prim_reg <= prim_next;
        end
    end

    // slot index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= head_valid;
            end
            if (load)
            begin
                idx_reg <= at_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    assign prim_valid = valid_reg;
    assign prim       = prim_reg;

endmodule

FILE: rtl/primitive_topology_expander.sv
`timescale 1ns / 1ps

// Primitive topology expander: turns a run of vertices into a flat triangle or
// line list according to mode_wdata written through mode_we (0 triangles,
// 1 lines, 2 triangle strip, 3 triangle fan, 4 line strip, 5 line loop, others
// drop). The output port emits one list vertex per cycle while prim_stall is low
// and the queue holds work. An input vertex produces one list vertex for lists,
// three for strips and fans once the run has two vertices, two for line strips
// after the first vertex, up to four on a line loop's closing vertex.
// The front stage takes a vertex every cycle while the job queue (QUEUE_DEPTH
// entries) has room; sustained rate is set by the single output port. An input
// transfer passes through the job queue and then the output register.
module primitive_topology_expander
    import pte_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mode_we,
    input  logic [2:0] mode_wdata,
    input  logic      vert_valid,
    output logic      vert_stall,
    input  vert_in_t  vert,
    output logic      prim_valid,
    input  logic      prim_stall,
    output prim_out_t prim
);

    logic push, push_ready, pop, head_valid;
    job_t push_job, head_job;

    // classify and expand
    pte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .vert_valid (vert_valid),
        .vert_stall (vert_stall),
        .vert       (vert),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    // job queue between the stages
    pte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // emit list vertices
    pte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .prim_valid (prim_valid),
        .prim_stall (prim_stall),
        .prim       (prim)
    );

endmodule

FILE: tb/tb_primitive_topology_expander.sv
`timescale 1ns / 1ps

module tb_primitive_topology_expander;
    import pte_pkg::*;

    // the two codes that drop every vertex
    localparam logic [2:0] MODE_DROP_LO = 3'd6;
    localparam logic [2:0] MODE_DROP_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 200000;

    // one row of the directed table: a mode write or a vertex transfer
    typedef struct {
        bit         is_cfg;
        logic [2:0] mode;
        vert_in_t   v;
        bit         typed;
        bit         typed_one;
        logic       typed_line;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      mode_we;
    logic [2:0] mode_wdata;
    logic      vert_valid;
    logic      vert_stall;
    vert_in_t  vert;
    logic      prim_valid;
    logic      prim_stall;
    prim_out_t prim;

    // expander model state
    logic [2:0] cur_mode = MODE_TRIS;
    vertex_t    first_v  = '0;
    vertex_t    older_v  = '0;
    vertex_t    newer_v  = '0;
    logic [1:0] seen_cnt = 2'd0;
    logic       odd_idx  = 1'b0;

    prim_out_t  fresh [4];
    int         fresh_n;
    prim_out_t  list_q [$];
    stim_row_t  stim_q [$];

    // hand-written expectation for the vertex on offer
    bit   hand_on   = 1'b0;
    bit   hand_one  = 1'b0;
    logic hand_line = 1'b0;

    int burst_left  = 0;
    bit hold_req    = 1'b0;
    int fail_count  = 0;
    int cycle_count = 0;

    primitive_topology_expander u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .vert_valid (vert_valid),
        .vert_stall (vert_stall),
        .vert       (vert),
        .prim_valid (prim_valid),
        .prim_stall (prim_stall),
        .prim       (prim)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("primitive_topology_expander test failed");
            $finish;
        end
    end

    function automatic void put_vertex(input vertex_t p, input logic line);
        fresh[fresh_n].out_x    = p.x;
        fresh[fresh_n].out_y    = p.y;
        fresh[fresh_n].is_line  = line;
        fresh[fresh_n].last_out = 1'b0;
        fresh_n++;
    endfunction

    // list vertices caused by one input vertex, and the history update
    function automatic void expand_vertex(input vert_in_t v);
        vertex_t cur;
        vertex_t first;
        cur.x   = v.vert_x;
        cur.y   = v.vert_y;
        first   = (seen_cnt == 2'd0) ? cur : first_v;
        fresh_n = 0;
        case (cur_mode)
            MODE_TRIS:  put_vertex(cur, 1'b0);
            MODE_LINES: put_vertex(cur, 1'b1);
            MODE_TSTRIP:
            begin
                if (seen_cnt >= 2'd2)
                begin
                    // odd positions swap the leading corners to keep the winding
                    if (!odd_idx)
                    begin
                        put_vertex(older_v, 1'b0);
                        put_vertex(newer_v, 1'b0);
                    end
                    else
                    begin
                        put_vertex(newer_v, 1'b0);
                        put_vertex(older_v, 1'b0);
                    end
                    put_vertex(cur, 1'b0);
                end
            end
            MODE_TFAN:
            begin
                if (seen_cnt >= 2'd2)
                begin
                    put_vertex(first, 1'b0);
                    put_vertex(newer_v, 1'b0);
                    put_vertex(cur, 1'b0);
                end
            end
            MODE_LSTRIP, MODE_LLOOP:
            begin
                if (seen_cnt >= 2'd1)
                begin
                    put_vertex(newer_v, 1'b1);
                    put_vertex(cur, 1'b1);
                end
                // closing segment of a loop
                if (cur_mode == MODE_LLOOP && v.run_end)
                begin
                    put_vertex(cur, 1'b1);
                    put_vertex(first, 1'b1);
                end
            end
            default: fresh_n = 0;
        endcase
        if (fresh_n > 0)
            fresh[fresh_n - 1].last_out = 1'b1;
        first_v = first;
        older_v = newer_v;
        newer_v = cur;
        if (seen_cnt < 2'd2)
            seen_cnt++;
        odd_idx = ~odd_idx;
        if (v.run_end)
        begin
            seen_cnt = 2'd0;
            odd_idx  = 1'b0;
        end
    endfunction

    // track mode writes and input transfers, check output transfers
    always @(posedge clk)
    begin
        prim_out_t want;
        if (rst_n)
        begin
            if (mode_we)
                cur_mode = mode_wdata;
            if (vert_valid && !vert_stall)
            begin
                expand_vertex(vert);
                if (hand_on)
                begin
                    fresh_n = 0;
                    if (hand_one)
                    begin
                        put_vertex('{y: vert.vert_y, x: vert.vert_x}, hand_line);
                        fresh[0].last_out = 1'b1;
                    end
                end
                for (int i = 0; i < fresh_n; i++)
                    list_q.insert(list_q.size(), fresh[i]);
            end
            if (prim_valid && !prim_stall)
            begin
                if (list_q.size() == 0)
                begin
                    $error("unexpected output transfer x %h y %h", prim.out_x, prim.out_y);
                    fail_count++;
                end
                else
                begin
                    want = list_q.pop_front();
                    if (prim.out_x !== want.out_x)
                    begin
                        $error("out_x expected %h actual %h", want.out_x, prim.out_x);
                        fail_count++;
                    end
                    if (prim.out_y !== want.out_y)
                    begin
                        $error("out_y expected %h actual %h", want.out_y, prim.out_y);
                        fail_count++;
                    end
                    if (prim.is_line !== want.is_line)
                    begin
                        $error("is_line expected %b actual %b", want.is_line, prim.is_line);
                        fail_count++;
                    end
                    if (prim.last_out !== want.last_out)
                    begin
                        $error("last_out expected %b actual %b", want.last_out, prim.last_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver: stretches of differing stall density, plus a long hold on request
    initial
    begin
        int stretch_left;
        int stall_pct;
        stretch_left = 0;
        stall_pct    = 0;
        prim_stall   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                prim_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                stretch_left--;
                prim_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic void add_row(input bit is_cfg, input logic [2:0] mode,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic run_end, input bit typed,
                                    input bit typed_one, input logic typed_line);
        stim_row_t r;
        r.is_cfg       = is_cfg;
        r.mode         = mode;
        r.v.vert_x     = x;
        r.v.vert_y     = y;
        r.v.run_end    = run_end;
        r.typed        = typed;
        r.typed_one    = typed_one;
        r.typed_line   = typed_line;
        stim_q.insert(stim_q.size(), r);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // stop offering, wait for every list vertex, then let the pipe go quiet
    task automatic settle_idle();
        vert_valid <= 1'b0;
        burst_left = 0;
        while (list_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        settle_idle();
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(negedge clk);
        mode_we    <= 1'b0;
    endtask

    // offer one vertex in bursts with random gaps, return after its transfer
    task automatic send_vertex(input vert_in_t v, input bit typed, input bit one,
                               input logic line);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 20) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                vert_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        hand_on   = typed;
        hand_one  = one;
        hand_line = line;
        vert       <= v;
        vert_valid <= 1'b1;
        @(posedge clk);
        while (vert_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    initial
    begin
        stim_row_t  row;
        vert_in_t   v;
        logic [2:0] m;
        int         runs;
        int         len;
        int         phase;
        int         random_items;

        rst_n      = 1'b0;
        mode_we    = 1'b0;
        mode_wdata = MODE_TRIS;
        vert_valid = 1'b0;
        vert       = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; the mode field of a vertex row is unused
        // triangle list after reset, coordinate extremes
        add_row(0, MODE_TRIS, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1, 1, 1'b0);
        add_row(0, MODE_TRIS, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1, 1, 1'b0);
        add_row(1, MODE_LINES, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1, 1, 1'b1);
        // triangle strip: two silent vertices, then even and odd windings
        add_row(1, MODE_TSTRIP, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h1, 32'h2, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h3, 32'h4, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h5, 32'h6, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h7, 32'h8, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h9, 32'hA, 1'b1, 0, 0, 1'b0);
        // fan
        add_row(1, MODE_TFAN, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h10, 32'h11, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h12, 32'h13, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h14, 32'h15, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h16, 32'h17, 1'b1, 0, 0, 1'b0);
        // line strip
        add_row(1, MODE_LSTRIP, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h20, 32'h21, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h22, 32'h23, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h24, 32'h25, 1'b1, 0, 0, 1'b0);
        // line loop: one-vertex degenerate segment, then a closed run
        add_row(1, MODE_LLOOP, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h30, 32'h31, 1'b1, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h32, 32'h33, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h34, 32'h35, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h36, 32'h37, 1'b1, 0, 0, 1'b0);
        // drop codes emit nothing
        add_row(1, MODE_DROP_LO, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1, 0, 1'b0);
        add_row(1, MODE_DROP_HI, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h0000_0000, 32'h0000_0000, 1'b1, 1, 0, 1'b0);
        // mode change mid-run keeps the history
        add_row(1, MODE_TSTRIP, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h40, 32'h41, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h42, 32'h43, 1'b0, 0, 0, 1'b0);
        add_row(1, MODE_TFAN, 0, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, MODE_TRIS, 32'h44, 32'h45, 1'b1, 0, 0, 1'b0);

        for (int r = 0; r < stim_q.size(); r++)
        begin
            row = stim_q[r];
            if (row.is_cfg)
                write_mode(row.mode);
            else
                send_vertex(row.v, row.typed, row.typed_one, row.typed_line);
        end

        // random runs; the first eight phases step through every mode code
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase < 8)
                m = phase[2:0];
            else
            begin
                case ($urandom_range(0, 9))
                    0:       m = MODE_TRIS;
                    1:       m = MODE_LINES;
                    2, 3:    m = MODE_TSTRIP;
                    4, 5:    m = MODE_TFAN;
                    6:       m = MODE_LSTRIP;
                    7, 8:    m = MODE_LLOOP;
                    default: m = $urandom_range(0, 1) ? MODE_DROP_HI : MODE_DROP_LO;
                endcase
            end
            write_mode(m);
            // long receiver hold while a strip keeps coming in
            if (phase == 2)
                hold_req = 1'b1;
            runs = (phase == 2) ? 1 : $urandom_range(1, 5);
            for (int run = 0; run < runs; run++)
            begin
                if (phase == 2)
                    len = 12;
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(7, 16);
                else
                    len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    v.vert_x  = pick_word();
                    v.vert_y  = pick_word();
                    v.run_end = (k == len - 1);
                    // stray run ends break runs short
                    if ($urandom_range(0, 19) == 0)
                        v.run_end = ~v.run_end;
                    // sometimes the run carries on into the next mode
                    if (run == runs - 1 && k == len - 1 && $urandom_range(0, 4) == 0)
                        v.run_end = 1'b0;
                    send_vertex(v, 0, 0, 1'b0);
                    random_items++;
                end
            end
            phase++;
        end

        settle_idle();
        if (fail_count == 0)
            $display("primitive_topology_expander test passed");
        else
            $display("primitive_topology_expander test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/pte_pkg.sv
rtl/pte_front.sv
rtl/pte_queue.sv
rtl/pte_back.sv
rtl/primitive_topology_expander.sv
tb/tb_primitive_topology_expander.sv
